FILE: hw/rtl/cc20_pkg.sv
package cc20_pkg;

  // Block function constants.
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam int unsigned ROUNDS = 20;
  localparam int unsigned ROUND_W = 5;
  localparam int unsigned WORDS_PER_BLOCK = 8;
  localparam int unsigned POS_W = 3;
  localparam int unsigned COUNT_W = 4;
  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  // Register map, in register order.
  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_INIT_CTR = 3'd6
  } cc20_reg_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_DONE
  } cc20_core_state_t;

  typedef logic [15:0][31:0] cc20_state_t;
  typedef logic [WORDS_PER_BLOCK-1:0][63:0] cc20_block_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_lo;
    logic [31:0]      nonce_hi;
    logic [31:0]      init_ctr;
  } cc20_cfg_t;

  // One classified word on its way to the back end.
  typedef struct packed {
    logic [63:0]        data;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   pos;
    logic               need_block;
  } cc20_entry_t;

  typedef struct packed {
    logic        done;
    cc20_block_t ks;
  } cc20_core_stat_t;

  // Initial block function state from configuration and block counter.
  function automatic cc20_state_t make_init(input cc20_cfg_t cfg, input logic [31:0] ctr);
    cc20_state_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2 * i] = cfg.key[i][31:0];
      s[5 + 2 * i] = cfg.key[i][63:32];
    end
    s[12] = ctr;
    s[13] = cfg.nonce_lo[31:0];
    s[14] = cfg.nonce_lo[63:32];
    s[15] = cfg.nonce_hi;
    return s;
  endfunction

  // Quarter round; result packed as {d, c, b, a}.
  function automatic logic [3:0][31:0] quarter(input logic [31:0] ai, input logic [31:0] bi,
                                               input logic [31:0] ci, input logic [31:0] di);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = ai;
    b = bi;
    c = ci;
    d = di;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    return {d, c, b, a};
  endfunction

  // One round: column round when diag is low, diagonal round otherwise.
  function automatic cc20_state_t one_round(input cc20_state_t x, input logic diag);
    cc20_state_t y;
    logic [3:0][31:0] q0;
    logic [3:0][31:0] q1;
    logic [3:0][31:0] q2;
    logic [3:0][31:0] q3;
    if (!diag) begin
      q0 = quarter(x[0], x[4], x[8],  x[12]);
      q1 = quarter(x[1], x[5], x[9],  x[13]);
      q2 = quarter(x[2], x[6], x[10], x[14]);
      q3 = quarter(x[3], x[7], x[11], x[15]);
      y[0] = q0[0]; y[4] = q0[1]; y[8]  = q0[2]; y[12] = q0[3];
      y[1] = q1[0]; y[5] = q1[1]; y[9]  = q1[2]; y[13] = q1[3];
      y[2] = q2[0]; y[6] = q2[1]; y[10] = q2[2]; y[14] = q2[3];
      y[3] = q3[0]; y[7] = q3[1]; y[11] = q3[2]; y[15] = q3[3];
    end else begin
      q0 = quarter(x[0], x[5], x[10], x[15]);
      q1 = quarter(x[1], x[6], x[11], x[12]);
      q2 = quarter(x[2], x[7], x[8],  x[13]);
      q3 = quarter(x[3], x[4], x[9],  x[14]);
      y[0] = q0[0]; y[5] = q0[1]; y[10] = q0[2]; y[15] = q0[3];
      y[1] = q1[0]; y[6] = q1[1]; y[11] = q1[2]; y[12] = q1[3];
      y[2] = q2[0]; y[7] = q2[1]; y[8]  = q2[2]; y[13] = q2[3];
      y[3] = q3[0]; y[4] = q3[1]; y[9]  = q3[2]; y[14] = q3[3];
    end
    return y;
  endfunction

  // Byte mask: bytes below the count pass, the rest are forced to zero.
  function automatic logic [63:0] byte_mask(input logic [COUNT_W-1:0] cnt);
    logic [63:0] m;
    for (int j = 0; j < 8; j++) begin
      m[8 * j +: 8] = (COUNT_W'(j) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/chacha20_stream_xor.sv
// An accepted word is written to the word queue and then to the output register when the keystream block is at hand;
// a word that opens a block waits for the block function.
// Throughput: 1 word per cycle within a block while the output is not stalled; each new block comes from the
// block function unit (one round per cycle, 20 rounds).
// The next block is computed while the current one drains.
// Reset (rst_n, synchronous): queues empty, counter and position cleared, registers zero.
module chacha20_stream_xor
  import cc20_pkg::*;
  #(parameter int unsigned QUEUE_DEPTH_LOG2 = 3)
  (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] data_in, [67:64] byte_count, [71:68] zero
  input  logic [0:0]  in_tuser,   // [0] message_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] data_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned ENTRY_W = $bits(cc20_entry_t);

  cc20_cfg_t                cfg_r;
  cc20_reg_t                reg_idx;
  logic                     cfg_wr;
  logic                     data_push;
  logic                     data_pop;
  logic                     data_full;
  logic                     data_empty;
  logic [QUEUE_DEPTH_LOG2:0] data_level;
  cc20_entry_t              entry_in;
  logic [ENTRY_W-1:0]       head_bits;
  cc20_entry_t              head;
  logic                     req_push;
  logic                     req_pop;
  logic                     req_full;
  logic                     req_empty;
  logic [QUEUE_DEPTH_LOG2:0] req_level;
  logic [31:0]              req_ctr_in;
  logic [31:0]              req_ctr;
  cc20_core_stat_t          core_stat;
  logic                     ks_take;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cc20_reg_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY0:     cfg_r.key[0]   <= cfg_pwdata;
        REG_KEY1:     cfg_r.key[1]   <= cfg_pwdata;
        REG_KEY2:     cfg_r.key[2]   <= cfg_pwdata;
        REG_KEY3:     cfg_r.key[3]   <= cfg_pwdata;
        REG_NONCE_LO: cfg_r.nonce_lo <= cfg_pwdata;
        REG_NONCE_HI: cfg_r.nonce_hi <= cfg_pwdata[31:0];
        REG_INIT_CTR: cfg_r.init_ctr <= cfg_pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_KEY0:     cfg_prdata = cfg_r.key[0];
      REG_KEY1:     cfg_prdata = cfg_r.key[1];
      REG_KEY2:     cfg_prdata = cfg_r.key[2];
      REG_KEY3:     cfg_prdata = cfg_r.key[3];
      REG_NONCE_LO: cfg_prdata = cfg_r.nonce_lo;
      REG_NONCE_HI: cfg_prdata = {32'd0, cfg_r.nonce_hi};
      REG_INIT_CTR: cfg_prdata = {32'd0, cfg_r.init_ctr};
      default:      cfg_prdata = '0;
    endcase
  end

  // Front end: classifies words and queues block requests.
  cc20_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .data_in       (in_tdata[63:0]),
    .byte_count    (in_tdata[67:64]),
    .message_start (in_tuser[0]),
    .init_ctr      (cfg_r.init_ctr),
    .data_full     (data_full),
    .req_full      (req_full),
    .data_push     (data_push),
    .entry         (entry_in),
    .req_push      (req_push),
    .req_ctr       (req_ctr_in)
  );

  // Word queue between front and back.
  cc20_queue #(
    .WIDTH      (ENTRY_W),
    .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
  ) u_data_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (data_push),
    .wr_data (entry_in),
    .full    (data_full),
    .rd_en   (data_pop),
    .rd_data (head_bits),
    .empty   (data_empty),
    .level   (data_level)
  );

  assign head = cc20_entry_t'(head_bits);

  // Block counter requests for the block function.
  cc20_queue #(
    .WIDTH      (32),
    .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
  ) u_req_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (req_push),
    .wr_data (req_ctr_in),
    .full    (req_full),
    .rd_en   (req_pop),
    .rd_data (req_ctr),
    .empty   (req_empty),
    .level   (req_level)
  );

  cc20_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (!req_empty),
    .req_ctr   (req_ctr),
    .req_pop   (req_pop),
    .take      (ks_take),
    .stat      (core_stat)
  );

  // Back end: XOR with keystream and output register.
  cc20_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!data_empty),
    .head       (head),
    .pop        (data_pop),
    .core       (core_stat),
    .take       (ks_take),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .data_out   (out_tdata)
  );

  // Every pending block request belongs to a word still waiting in the word queue.
  assert property (@(posedge clk) disable iff (!rst_n) req_level <= data_level)
    else $error("block request without a queued word");

  // A keystream block is taken only once the block function has finished it.
  assert property (@(posedge clk) disable iff (!rst_n) ks_take |-> core_stat.done)
    else $error("keystream taken before block function finished");

  // A word that opens a block is never consumed while no request is outstanding or running.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!data_empty && head.need_block && req_empty && !core_stat.done) |=> !ks_take ||
    core_stat.done)
    else $error("block word consumed without keystream");

endmodule

FILE: hw/rtl/cc20_queue.sv
module cc20_queue
  #(parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH_LOG2 = 3)
  (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [WIDTH-1:0]      wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty,
  output logic [DEPTH_LOG2:0]   level
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r;
  logic [DEPTH_LOG2-1:0] rd_ptr_r;
  logic [DEPTH_LOG2:0]   level_r;

  assign full    = (level_r == (DEPTH_LOG2 + 1)'(DEPTH));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign rd_data = mem_r[rd_ptr_r];

  // Storage array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        level_r <= level_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/cc20_front.sv
module cc20_front
  import cc20_pkg::*;
  (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       data_in,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic              message_start,
  input  logic [31:0]       init_ctr,
  input  logic              data_full,
  input  logic              req_full,
  output logic              data_push,
  output cc20_entry_t       entry,
  output logic              req_push,
  output logic [31:0]       req_ctr
);

  logic             restart_r;
  logic [POS_W-1:0] pos_r;
  logic [31:0]      ctr_r;
  logic             restart;
  logic [POS_W-1:0] pos;
  logic [31:0]      ctr;
  logic             need_block;
  logic             accept;

  assign in_ready = !data_full && !req_full;
  assign accept   = in_valid && in_ready;

  // Classify the word: a fresh message reloads the counter, position zero needs a block.
  always_comb begin
    restart    = message_start || restart_r;
    pos        = restart ? '0 : pos_r;
    ctr        = restart ? init_ctr : ctr_r;
    need_block = (pos == '0);
  end

  assign data_push        = accept;
  assign req_push         = accept && need_block;
  assign req_ctr          = ctr;
  assign entry.data       = data_in;
  assign entry.count      = byte_count;
  assign entry.pos        = pos;
  assign entry.need_block = need_block;

  // Message position and block counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
      pos_r     <= '0;
      ctr_r     <= '0;
    end else if (accept) begin
      pos_r     <= pos + 1'b1;
      ctr_r     <= need_block ? ctr + 32'd1 : ctr;
      restart_r <= (byte_count < FULL_COUNT);
    end
  end

endmodule

FILE: hw/rtl/cc20_core.sv
module cc20_core
  import cc20_pkg::*;
  (
  input  logic            clk,
  input  logic            rst_n,
  input  cc20_cfg_t       cfg,
  input  logic            req_valid,
  input  logic [31:0]     req_ctr,
  output logic            req_pop,
  input  logic            take,
  output cc20_core_stat_t stat
);

  cc20_core_state_t   state_r;
  cc20_core_state_t   state_nxt;
  cc20_state_t        x_r;
  logic [31:0]        ctr_r;
  logic [ROUND_W-1:0] round_r;
  logic               last_round;
  cc20_state_t        init_ctl;
  cc20_state_t        init_req;

  assign init_req   = make_init(cfg, req_ctr);
  assign init_ctl   = make_init(cfg, ctr_r);
  assign last_round = (round_r == ROUND_W'(ROUNDS - 1));

  // Sequencer: wait for a request, run the rounds, hold the block until taken.
  always_comb begin
    state_nxt = state_r;
    req_pop   = 1'b0;
    case (state_r)
      CORE_IDLE: begin
        if (req_valid) begin
          req_pop   = 1'b1;
          state_nxt = CORE_RUN;
        end
      end
      CORE_RUN: begin
        if (last_round) begin
          state_nxt = CORE_DONE;
        end
      end
      CORE_DONE: begin
        if (take) begin
          state_nxt = CORE_IDLE;
        end
      end
      default: begin
        state_nxt = CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CORE_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == CORE_RUN) begin
        round_r <= last_round ? '0 : round_r + 1'b1;
      end
    end
  end

  // Working state: one column or diagonal round per cycle.
  always_ff @(posedge clk) begin
    if (req_pop) begin
      x_r   <= init_req;
      ctr_r <= req_ctr;
    end else if (state_r == CORE_RUN) begin
      x_r <= one_round(x_r, round_r[0]);
    end
  end

  // Final feed-forward add forms the keystream block.
  always_comb begin
    stat.done = (state_r == CORE_DONE);
    for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
      stat.ks[i] = {x_r[2 * i + 1] + init_ctl[2 * i + 1], x_r[2 * i] + init_ctl[2 * i]};
    end
  end

endmodule

FILE: hw/rtl/cc20_back.sv
module cc20_back
  import cc20_pkg::*;
  (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  cc20_entry_t     head,
  output logic            pop,
  input  cc20_core_stat_t core,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     data_out
);

  logic [63:0] ks_r [WORDS_PER_BLOCK];
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_load;
  logic        fire;
  logic [63:0] ks_word;

  assign out_load  = !out_valid_r || out_ready;
  assign fire      = head_valid && out_load && (!head.need_block || core.done);
  assign pop       = fire;
  assign take      = fire && head.need_block;
  assign ks_word   = head.need_block ? core.ks[0] : ks_r[head.pos];
  assign out_valid = out_valid_r;
  assign data_out  = out_data_r;

  // Current keystream block, loaded when its first word goes out.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
        ks_r[i] <= core.ks[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= (head.data ^ ks_word) & byte_mask(head.count);
    end
  end

endmodule

FILE: sim/chacha20_stream_xor_test.sv
module chacha20_stream_xor_test
  import cc20_pkg::*;
  ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned SEGMENTS = 8;
  localparam int unsigned WORDS_PER_SEGMENT = 50;
  localparam int unsigned BYTES_PER_WORD = 8;
  localparam logic [31:0] EXPAND_0 = 32'h61707865;
  localparam logic [31:0] EXPAND_1 = 32'h3320646e;
  localparam logic [31:0] EXPAND_2 = 32'h79622d32;
  localparam logic [31:0] EXPAND_3 = 32'h6b206574;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  // One directed word; the expected output is only typed in where it is obvious.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        start;
    logic        typed;
    logic [63:0] want;
  } word_row_t;

  localparam int unsigned DIRECTED_N = 19;
  localparam word_row_t DIRECTED_WORDS [0:DIRECTED_N-1] = '{
    // First word after reset opens a message without the start flag.
    '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 64'h0},
    '{ALL_ONES,                4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h0123_4567_89ab_cdef, 4'd8,  1'b0, 1'b0, 64'h0},
    // Counts above eight saturate to a full word.
    '{64'hfedc_ba98_7654_3210, 4'd15, 1'b0, 1'b0, 64'h0},
    '{64'h5555_aaaa_5555_aaaa, 4'd9,  1'b0, 1'b0, 64'h0},
    '{64'haaaa_5555_aaaa_5555, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0001, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h7fff_ffff_ffff_fffe, 4'd8,  1'b0, 1'b0, 64'h0},
    // Ninth word crosses into the second block.
    '{ALL_ONES,                4'd8,  1'b0, 1'b0, 64'h0},
    // A zero count gives zero and ends the message.
    '{ALL_ONES,                4'd0,  1'b0, 1'b1, 64'h0},
    // Word after a short word restarts the message by itself.
    '{ALL_ONES,                4'd8,  1'b0, 1'b0, 64'h0},
    '{ALL_ONES,                4'd1,  1'b0, 1'b0, 64'h0},
    '{ALL_ONES,                4'd7,  1'b1, 1'b0, 64'h0},
    '{64'h0f0f_0f0f_0f0f_0f0f, 4'd8,  1'b1, 1'b0, 64'h0},
    '{64'hf0f0_f0f0_f0f0_f0f0, 4'd8,  1'b0, 1'b0, 64'h0},
    // Start flag in the middle of a block.
    '{64'h1122_3344_5566_7788, 4'd8,  1'b1, 1'b0, 64'h0},
    '{ALL_ONES,                4'd3,  1'b0, 1'b0, 64'h0},
    '{ALL_ONES,                4'd0,  1'b1, 1'b1, 64'h0},
    '{ALL_ONES,                4'd8,  1'b1, 1'b0, 64'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // [63:0] data_in, [67:64] byte_count, [71:68] zero
  logic [0:0]  in_tuser;   // [0] message_start
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] data_out
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  chacha20_stream_xor uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Cipher settings as the block should hold them.
  logic [3:0][63:0] key_setting;
  logic [63:0]      nonce_lo_setting;
  logic [31:0]      nonce_hi_setting;
  logic [31:0]      start_ctr_setting;

  // Keystream position of the message in flight.
  logic [7:0][63:0] keystream_words;
  logic [31:0]      next_block_ctr;
  logic [2:0]       word_index;
  logic             restart_due;

  logic [63:0] expected_words[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  // Random message shaping.
  int unsigned words_left;
  logic        last_was_short;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("chacha20_stream_xor verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [15:0][31:0] quarter_round(input logic [15:0][31:0] s,
                                                      input int a, input int b,
                                                      input int c, input int d);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
    return s;
  endfunction

  // Block function: 64 keystream bytes for one counter value.
  function automatic logic [7:0][63:0] keystream_block(input logic [31:0] ctr);
    logic [15:0][31:0] init;
    logic [15:0][31:0] mix;
    logic [7:0][63:0]  blk;
    init[0] = EXPAND_0;
    init[1] = EXPAND_1;
    init[2] = EXPAND_2;
    init[3] = EXPAND_3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_setting[i][31:0];
      init[5 + 2 * i] = key_setting[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_lo_setting[31:0];
    init[14] = nonce_lo_setting[63:32];
    init[15] = nonce_hi_setting;
    mix = init;
    for (int r = 0; r < 10; r++) begin
      mix = quarter_round(mix, 0, 4, 8, 12);
      mix = quarter_round(mix, 1, 5, 9, 13);
      mix = quarter_round(mix, 2, 6, 10, 14);
      mix = quarter_round(mix, 3, 7, 11, 15);
      mix = quarter_round(mix, 0, 5, 10, 15);
      mix = quarter_round(mix, 1, 6, 11, 12);
      mix = quarter_round(mix, 2, 7, 8, 13);
      mix = quarter_round(mix, 3, 4, 9, 14);
    end
    for (int i = 0; i < 8; i++) begin
      blk[i] = {mix[2 * i + 1] + init[2 * i + 1], mix[2 * i] + init[2 * i]};
    end
    return blk;
  endfunction

  // Encrypts one word and advances the message position.
  function automatic logic [63:0] crypt_word(input logic [63:0] data, input logic [3:0] count,
                                             input logic start);
    logic [63:0] keep;
    int          valid_bytes;
    logic [63:0] result;
    if (start || restart_due) begin
      next_block_ctr = start_ctr_setting;
      word_index = '0;
      restart_due = 1'b0;
    end
    if (word_index == 0) begin
      keystream_words = keystream_block(next_block_ctr);
      next_block_ctr = next_block_ctr + 32'd1;
    end
    valid_bytes = (count > BYTES_PER_WORD) ? BYTES_PER_WORD : int'(count);
    for (int j = 0; j < 8; j++) begin
      keep[8 * j +: 8] = (j < valid_bytes) ? 8'hff : 8'h00;
    end
    result = (data ^ keystream_words[word_index]) & keep;
    word_index = word_index + 3'd1;
    if (valid_bytes < BYTES_PER_WORD) begin
      restart_due = 1'b1;
    end
    return result;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Result checking, oldest expectation first.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected output word", out_tdata, 64'h0);
      end else begin
        if (out_tdata !== expected_words[0]) begin
          report_mismatch("data_out", out_tdata, expected_words[0]);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(1, 100) > receiver_stall_pct);
  end

  // Register write with a setup phase and an access phase; called at a falling edge.
  task automatic write_reg(input cc20_reg_t idx, input logic [63:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 3'b000};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      REG_KEY0:     key_setting[0] = value;
      REG_KEY1:     key_setting[1] = value;
      REG_KEY2:     key_setting[2] = value;
      REG_KEY3:     key_setting[3] = value;
      REG_NONCE_LO: nonce_lo_setting = value;
      REG_NONCE_HI: nonce_hi_setting = value[31:0];
      REG_INIT_CTR: start_ctr_setting = value[31:0];
      default: ;
    endcase
  endtask

  // Sends one word; called and returns at a falling edge, tvalid left high.
  task automatic send_word(input logic [63:0] data, input logic [3:0] count, input logic start,
                           input logic typed, input logic [63:0] want);
    logic [63:0] predicted;
    while ($urandom_range(1, 100) <= sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {4'b0000, count, data};
    in_tuser = start;
    do @(posedge clk); while (!in_tready);
    predicted = crypt_word(data, count, start);
    expected_words.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Lets the block empty out before settings change.
  task automatic drain;
    in_tvalid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(input int unsigned seg);
    logic [63:0] ctr;
    for (int i = 0; i < 6; i++) begin
      case (seg)
        0:       write_reg(cc20_reg_t'(i), ALL_ONES);
        4:       write_reg(cc20_reg_t'(i), 64'h0);
        default: write_reg(cc20_reg_t'(i), {$urandom, $urandom});
      endcase
    end
    case ($urandom_range(0, 3))
      0:       ctr = {$urandom, 32'h0};
      1:       ctr = {$urandom, 32'hffff_ffff};
      2:       ctr = {$urandom, 32'hffff_fffe};
      default: ctr = {$urandom, $urandom};
    endcase
    if (seg == 0) begin
      ctr = ALL_ONES;
    end else if (seg == 4) begin
      ctr = 64'h0;
    end
    write_reg(REG_INIT_CTR, ctr);
  endtask

  // Mostly whole messages with random content; some words are noise.
  task automatic random_word;
    logic [63:0] data;
    logic [3:0]  count;
    logic        start;
    data = {$urandom, $urandom};
    start = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      count = 4'($urandom_range(0, 15));
      start = 1'($urandom_range(0, 1));
      if (count < BYTES_PER_WORD) begin
        words_left = 0;
      end
    end else begin
      if (words_left == 0) begin
        words_left = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        start = last_was_short ? 1'($urandom_range(0, 1)) : 1'b1;
      end
      words_left--;
      if (words_left == 0 && $urandom_range(0, 3) != 0) begin
        count = 4'($urandom_range(0, 7));
      end else begin
        count = 4'(BYTES_PER_WORD);
      end
    end
    last_was_short = (count < BYTES_PER_WORD);
    send_word(data, count, start, 1'b0, 64'h0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    words_left = 0;
    last_was_short = 1'b1;
    key_setting = '0;
    nonce_lo_setting = '0;
    nonce_hi_setting = '0;
    start_ctr_setting = '0;
    keystream_words = '0;
    next_block_ctr = '0;
    word_index = '0;
    restart_due = 1'b1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words with the registers at their reset values.
    for (int r = 0; r < DIRECTED_N; r++) begin
      send_word(DIRECTED_WORDS[r].data, DIRECTED_WORDS[r].count, DIRECTED_WORDS[r].start,
                DIRECTED_WORDS[r].typed, DIRECTED_WORDS[r].want);
    end
    drain();

    // Random segments; a message may stay open across a settings change.
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      endcase
      load_settings(seg);
      for (int unsigned n = 0; n < WORDS_PER_SEGMENT; n++) begin
        random_word();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("chacha20_stream_xor verification clean");
    end else begin
      $display("chacha20_stream_xor verification failed");
    end
    $finish;
  end

endmodule
